@@ rtl/assert_macros.svh @@
// Assertion helpers for the files that check their own logic.
// Both forms sample on the rising edge of aclk and are off while aresetn is low.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// A property that must hold at every sampled edge.
`define KMG_ASSERT(lbl, prop) \
    lbl: assert property (@(posedge aclk) disable iff (!aresetn) (prop)) \
        else $error("key matrix block: assertion failed");

// A condition at one edge that must be followed by another at the next edge.
`define KMG_ASSERT_NEXT(lbl, cond, nxt) \
    lbl: assert property (@(posedge aclk) disable iff (!aresetn) (cond) |=> (nxt)) \
        else $error("key matrix block: assertion failed");

`endif

@@ rtl/kmgbd_pkg.sv @@
package kmgbd_pkg;

    // Matrix size in rows and columns, 2 to 8.
    localparam int MATRIX_DIM  = 8;
    localparam int ROW_STRIDE  = 8;
    localparam int MATRIX_KEYS = 64;
    localparam int KEY_COUNT   = MATRIX_KEYS + 1;
    localparam int KEY_W       = $clog2(KEY_COUNT);
    localparam int ROW_W       = $clog2(MATRIX_DIM);
    localparam int CNT_W       = 8;

    localparam logic [KEY_W-1:0] EXTRA_KEY    = KEY_W'(MATRIX_KEYS);
    localparam logic [ROW_W-1:0] LAST_ROW     = ROW_W'(MATRIX_DIM - 2);
    localparam logic [CNT_W-1:0] COUNT_MAX    = {CNT_W{1'b1}};
    localparam logic [CNT_W-1:0] THRESH_RESET = CNT_W'(10);

    localparam int Q_DEPTH = 2;
    localparam int Q_PTR_W = $clog2(Q_DEPTH);
    localparam int Q_LVL_W = $clog2(Q_DEPTH + 1);

    // One cleaned-up scan: 1 means pressed.
    typedef struct packed {
        logic [MATRIX_KEYS-1:0] keys;
        logic                   extra;
    } scan_t;

    typedef struct packed {
        logic               full;
        logic               empty;
        logic [Q_LVL_W-1:0] level;
    } fifo_status_t;

    function automatic logic [5:0] key_idx(input int col, input int row);
        return 6'(col * ROW_STRIDE + row);
    endfunction

    function automatic logic [MATRIX_KEYS-1:0] scanned_mask();
        logic [MATRIX_KEYS-1:0] m;
        m = '0;
        for (int c = 0; c < MATRIX_DIM; c++) begin
            for (int r = 0; r < MATRIX_DIM; r++) begin
                m[key_idx(c, r)] = 1'b1;
            end
        end
        return m;
    endfunction

endpackage

@@ rtl/kmgbd_front.sv @@
// Takes a scan, inverts it and walks the ghost check one row pair per cycle.
module kmgbd_front (
    input  logic             aclk,
    input  logic             aresetn,
    input  logic             s_valid,
    output logic             s_ready,
    input  logic [63:0]      s_matrix_levels,
    input  logic             s_restore_level,
    output logic             q_valid,
    input  logic             q_ready,
    output kmgbd_pkg::scan_t q_data
);

    localparam logic [1:0] F_IDLE  = 2'd0;
    localparam logic [1:0] F_GHOST = 2'd1;
    localparam logic [1:0] F_PUSH  = 2'd2;

    logic [1:0] state_reg, state_next;
    logic [kmgbd_pkg::ROW_W-1:0] row_reg, row_next;
    logic [kmgbd_pkg::MATRIX_KEYS-1:0] raw_reg, raw_next;
    logic extra_reg, extra_next;

    logic [kmgbd_pkg::MATRIX_DIM-1:0] both;
    logic multi;
    logic [kmgbd_pkg::MATRIX_KEYS-1:0] cleared;

    // Columns with both rows of the current pair pressed; two or more block the pair.
    always_comb begin
        both = '0;
        for (int c = 0; c < kmgbd_pkg::MATRIX_DIM; c++) begin
            both[c] = raw_reg[kmgbd_pkg::key_idx(c, int'(row_reg))]
                    & raw_reg[kmgbd_pkg::key_idx(c, int'(row_reg) + 1)];
        end
        multi   = |(both & (both - 1'b1));
        cleared = raw_reg;
        if (multi) begin
            for (int c = 0; c < kmgbd_pkg::MATRIX_DIM; c++) begin
                cleared[kmgbd_pkg::key_idx(c, int'(row_reg))]     = 1'b0;
                cleared[kmgbd_pkg::key_idx(c, int'(row_reg) + 1)] = 1'b0;
            end
        end
    end

    always_comb begin
        state_next = state_reg;
        row_next   = row_reg;
        raw_next   = raw_reg;
        extra_next = extra_reg;
        unique case (state_reg)
            F_IDLE: begin
                if (s_valid) begin
                    raw_next   = ~s_matrix_levels & kmgbd_pkg::scanned_mask();
                    extra_next = ~s_restore_level;
                    row_next   = '0;
                    state_next = F_GHOST;
                end
            end
            F_GHOST: begin
                raw_next = cleared;
                if (row_reg == kmgbd_pkg::LAST_ROW) begin
                    state_next = F_PUSH;
                end else begin
                    row_next = row_reg + 1'b1;
                end
            end
            F_PUSH: begin
                if (q_ready) begin
                    state_next = F_IDLE;
                end
            end
            default: begin
                state_next = F_IDLE;
            end
        endcase
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg <= F_IDLE;
        end else begin
            state_reg <= state_next;
        end
        row_reg   <= row_next;
        raw_reg   <= raw_next;
        extra_reg <= extra_next;
    end

    assign s_ready      = (state_reg == F_IDLE);
    assign q_valid      = (state_reg == F_PUSH);
    assign q_data.keys  = raw_reg;
    assign q_data.extra = extra_reg;

endmodule

@@ rtl/kmgbd_fifo.sv @@
// Short queue of cleaned scans between the ghost walker and the debouncer.
module kmgbd_fifo (
    input  logic                    aclk,
    input  logic                    aresetn,
    input  logic                    in_valid,
    output logic                    in_ready,
    input  kmgbd_pkg::scan_t        in_data,
    output logic                    out_valid,
    input  logic                    out_ready,
    output kmgbd_pkg::scan_t        out_data,
    output kmgbd_pkg::fifo_status_t status
);

    kmgbd_pkg::scan_t entry_reg [kmgbd_pkg::Q_DEPTH];
    logic [kmgbd_pkg::Q_PTR_W-1:0] wr_ptr_reg, rd_ptr_reg;
    logic [kmgbd_pkg::Q_LVL_W-1:0] level_reg, level_next;
    logic push, pop;

    assign status.full  = (level_reg == kmgbd_pkg::Q_LVL_W'(kmgbd_pkg::Q_DEPTH));
    assign status.empty = (level_reg == '0);
    assign status.level = level_reg;

    assign in_ready  = !status.full;
    assign out_valid = !status.empty;
    assign out_data  = entry_reg[rd_ptr_reg];
    assign push      = in_valid && in_ready;
    assign pop       = out_valid && out_ready;

    always_comb begin
        level_next = level_reg;
        if (push && !pop) begin
            level_next = level_reg + 1'b1;
        end else if (pop && !push) begin
            level_next = level_reg - 1'b1;
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            wr_ptr_reg <= '0;
            rd_ptr_reg <= '0;
            level_reg  <= '0;
        end else begin
            if (push) begin
                wr_ptr_reg <= wr_ptr_reg + 1'b1;
            end
            if (pop) begin
                rd_ptr_reg <= rd_ptr_reg + 1'b1;
            end
            level_reg <= level_next;
        end
        if (push) begin
            entry_reg[wr_ptr_reg] <= in_data;
        end
    end

endmodule

@@ rtl/kmgbd_back.sv @@
// Runs the counter debounce over all keys, one key per cycle, through a
// count memory with a registered read.
module kmgbd_back (
    input  logic                            aclk,
    input  logic                            aresetn,
    input  logic [kmgbd_pkg::CNT_W-1:0]     threshold,
    input  logic                            q_valid,
    output logic                            q_ready,
    input  kmgbd_pkg::scan_t                q_data,
    output logic                            m_valid,
    input  logic                            m_ready,
    output logic [63:0]                     m_pressed_keys,
    output logic                            m_extra_pressed
);

    localparam logic [1:0] B_IDLE = 2'd0;
    localparam logic [1:0] B_RUN  = 2'd1;
    localparam logic [1:0] B_FIN  = 2'd2;

    logic [1:0] state_reg, state_next;
    kmgbd_pkg::scan_t scan_reg;
    logic [kmgbd_pkg::KEY_W-1:0] key_reg;

    logic [kmgbd_pkg::CNT_W-1:0] count_mem [kmgbd_pkg::KEY_COUNT];
    logic [kmgbd_pkg::CNT_W-1:0] rd_data_reg;
    logic [kmgbd_pkg::KEY_COUNT-1:0] cnt_valid_reg;
    logic [kmgbd_pkg::KEY_COUNT-1:0] held_reg;

    logic b_valid_reg;
    logic [kmgbd_pkg::KEY_W-1:0] b_key_reg;
    logic b_raw_reg;

    logic issue;
    logic a_raw;
    logic [kmgbd_pkg::CNT_W-1:0] cnt_cur, cnt_next;
    logic held_cur, held_next;

    logic m_valid_reg;
    logic [63:0] pressed_reg;
    logic extra_reg;

    assign q_ready = (state_reg == B_IDLE) && !m_valid_reg;
    assign issue   = (state_reg == B_RUN);
    assign a_raw   = (key_reg == kmgbd_pkg::EXTRA_KEY) ? scan_reg.extra
                                                       : scan_reg.keys[key_reg[5:0]];

    always_comb begin
        state_next = state_reg;
        unique case (state_reg)
            B_IDLE: begin
                if (q_valid && q_ready) begin
                    state_next = B_RUN;
                end
            end
            B_RUN: begin
                if (key_reg == kmgbd_pkg::EXTRA_KEY) begin
                    state_next = B_FIN;
                end
            end
            B_FIN: begin
                state_next = B_IDLE;
            end
            default: begin
                state_next = B_IDLE;
            end
        endcase
    end

    // Debounce of the key in the second stage.
    always_comb begin
        cnt_cur   = cnt_valid_reg[b_key_reg] ? rd_data_reg : '0;
        held_cur  = held_reg[b_key_reg];
        held_next = held_cur;
        cnt_next  = '0;
        if (b_raw_reg != held_cur) begin
            if (cnt_cur > threshold) begin
                held_next = b_raw_reg;
            end else if (cnt_cur < kmgbd_pkg::COUNT_MAX) begin
                cnt_next = cnt_cur + 1'b1;
            end else begin
                cnt_next = cnt_cur;
            end
        end
    end

    always_ff @(posedge aclk) begin
        rd_data_reg <= count_mem[key_reg];
        if (b_valid_reg) begin
            count_mem[b_key_reg] <= cnt_next;
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg     <= B_IDLE;
            b_valid_reg   <= 1'b0;
            cnt_valid_reg <= '0;
            held_reg      <= '0;
            m_valid_reg   <= 1'b0;
        end else begin
            state_reg   <= state_next;
            b_valid_reg <= issue;
            if (b_valid_reg) begin
                cnt_valid_reg[b_key_reg] <= 1'b1;
                held_reg[b_key_reg]      <= held_next;
            end
            if (state_reg == B_FIN) begin
                m_valid_reg <= 1'b1;
            end else if (m_ready) begin
                m_valid_reg <= 1'b0;
            end
        end
        if (q_valid && q_ready) begin
            scan_reg <= q_data;
            key_reg  <= '0;
        end else if (issue && key_reg != kmgbd_pkg::EXTRA_KEY) begin
            key_reg <= key_reg + 1'b1;
        end
        b_key_reg <= key_reg;
        b_raw_reg <= a_raw;
        if (state_reg == B_FIN) begin
            pressed_reg <= held_reg[kmgbd_pkg::MATRIX_KEYS-1:0];
            extra_reg   <= held_next;
        end
    end

    assign m_valid         = m_valid_reg;
    assign m_pressed_keys  = pressed_reg;
    assign m_extra_pressed = extra_reg;

endmodule

@@ rtl/key_matrix_ghost_block_debounce_top.sv @@
// Channel   Direction  Ports                                     Item
// s_        in         s_valid s_ready s_matrix_levels,          one raw matrix scan
//                      s_restore_level
// m_        out        m_valid m_ready m_pressed_keys,           debounced key states
//                      m_extra_pressed
// cfg_      in         cfg_wr_en cfg_wr_data                     debounce threshold
//
// The front walks the ghost check one row pair per cycle and then hands the cleaned scan
// to a two-entry queue. The back accepts a scan, runs the debounce over all 65 keys,
// finishes the last key and hands over the result; it accepts the next scan only once
// that result has been taken, and this walk, not the front, limits the flow of scans.
// Reset (aresetn low, synchronous) releases all keys, clears all counts through per-key
// valid bits and sets the threshold to 10. A stalled result holds the back; the front
// keeps taking scans until the queue fills.
`include "assert_macros.svh"

module key_matrix_ghost_block_debounce_top (
    input  logic        aclk,
    input  logic        aresetn,
    input  logic        s_valid,
    output logic        s_ready,
    input  logic [63:0] s_matrix_levels,
    input  logic        s_restore_level,
    output logic        m_valid,
    input  logic        m_ready,
    output logic [63:0] m_pressed_keys,
    output logic        m_extra_pressed,
    input  logic        cfg_wr_en,
    input  logic [7:0]  cfg_wr_data
);

    // The threshold is to be rewritten only while the block is idle, so the back may read it
    // directly; this binds the user, and the block itself leaves it unenforced.
    logic [kmgbd_pkg::CNT_W-1:0] threshold_reg;

    logic fq_valid, fq_ready;
    kmgbd_pkg::scan_t fq_data;
    logic qb_valid, qb_ready;
    kmgbd_pkg::scan_t qb_data;
    kmgbd_pkg::fifo_status_t q_status;

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            threshold_reg <= kmgbd_pkg::THRESH_RESET;
        end else if (cfg_wr_en) begin
            threshold_reg <= cfg_wr_data;
        end
    end

    // Front: inversion, scan mask and ghost blocking.
    kmgbd_front u_front (
        .aclk            (aclk),
        .aresetn         (aresetn),
        .s_valid         (s_valid),
        .s_ready         (s_ready),
        .s_matrix_levels (s_matrix_levels),
        .s_restore_level (s_restore_level),
        .q_valid         (fq_valid),
        .q_ready         (fq_ready),
        .q_data          (fq_data)
    );

    // Queue that lets the front and back stall on their own.
    kmgbd_fifo u_fifo (
        .aclk      (aclk),
        .aresetn   (aresetn),
        .in_valid  (fq_valid),
        .in_ready  (fq_ready),
        .in_data   (fq_data),
        .out_valid (qb_valid),
        .out_ready (qb_ready),
        .out_data  (qb_data),
        .status    (q_status)
    );

    // Back: per-key counter debounce and the result register.
    kmgbd_back u_back (
        .aclk            (aclk),
        .aresetn         (aresetn),
        .threshold       (threshold_reg),
        .q_valid         (qb_valid),
        .q_ready         (qb_ready),
        .q_data          (qb_data),
        .m_valid         (m_valid),
        .m_ready         (m_ready),
        .m_pressed_keys  (m_pressed_keys),
        .m_extra_pressed (m_extra_pressed)
    );

    // The queue never holds more scans than it has entries.
    `KMG_ASSERT(a_queue_level, q_status.level <= kmgbd_pkg::Q_LVL_W'(kmgbd_pkg::Q_DEPTH))
    // Once the front takes a scan it is busy on the ghost walk in the next cycle.
    `KMG_ASSERT_NEXT(a_front_busy, s_valid && s_ready, !s_ready)
    // The back starts a scan only while no result is waiting.
    `KMG_ASSERT(a_pop_slot_free, !(qb_valid && qb_ready && m_valid))

endmodule
